### rtl/core/glc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// glc_pkg
// Shared sizes and types for the glyph cache tag store.
// ----------------------------------------------------------------------------
package glc_pkg;

  localparam int ENTRIES     = 512;
  localparam int STAMP_WIDTH = 32;

  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int GLYPH_W = 16;
  localparam int SIZE_W  = 10;
  localparam int STYLE_W = 8;
  localparam int ANGLE_W = 32;
  localparam int SLOT_W  = 9;
  localparam int KEY_W   = GLYPH_W + SIZE_W + STYLE_W;
  localparam int WORD_W  = KEY_W + ANGLE_W + STAMP_WIDTH;

  localparam logic [STAMP_WIDTH-1:0] STAMP_MAX = {STAMP_WIDTH{1'b1}};

  typedef logic [KEY_W-1:0]       key_t;
  typedef logic [ANGLE_W-1:0]     angle_t;
  typedef logic [STAMP_WIDTH-1:0] stamp_t;

  typedef struct packed {
    key_t   key;
    angle_t angle;
    stamp_t stamp;
  } entry_t;

endpackage

`default_nettype wire

### rtl/core/glc_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// glc_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module glc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/core/glyph_cache_lru_lookup_top.sv
`default_nettype none
// Lookup: the slots in use are read in order from slot 0; a hit stops at the matching slot,
// a miss reads every slot in use (none on an empty store).
// Throughput: one request at a time; in_ready rises again in the cycle after the result is accepted.
// Reset: synchronous, active low; clears fill count, stamp counter and control state.
// The tag RAM is not cleared; slots at or above the fill count are treated as free.
// ----------------------------------------------------------------------------
// glyph_cache_lru_lookup_top
// Fully associative glyph tag store with least-recent-stamp replacement.
// ----------------------------------------------------------------------------
module glyph_cache_lru_lookup_top (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [glc_pkg::GLYPH_W-1:0] in_glyph_index,
  input  wire logic [glc_pkg::SIZE_W-1:0]  in_pixel_size,
  input  wire logic [glc_pkg::STYLE_W-1:0] in_style_bits,
  input  wire logic signed [glc_pkg::ANGLE_W-1:0] in_rotation,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             out_hit,
  output logic [glc_pkg::SLOT_W-1:0]       out_slot,
  output logic                             out_evicted
);

  import glc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_RESP
  } state_t;

  state_t             state_r, state_nxt;
  key_t               key_r, key_nxt;
  angle_t             angle_r, angle_nxt;
  logic [CNT_W-1:0]   addr_r, addr_nxt;
  logic [CNT_W-1:0]   fill_r, fill_nxt;
  logic               pend_r, pend_nxt;
  logic [IDX_W-1:0]   pidx_r, pidx_nxt;
  logic               have_old_r, have_old_nxt;
  stamp_t             old_stamp_r, old_stamp_nxt;
  logic [IDX_W-1:0]   old_slot_r, old_slot_nxt;
  logic [IDX_W-1:0]   target_r, target_nxt;
  logic               hit_r, hit_nxt;
  logic               evict_r, evict_nxt;
  stamp_t             counter_r, counter_nxt;

  logic               ram_we;
  entry_t             ram_wdata;
  logic [WORD_W-1:0]  ram_rdata;
  entry_t             rd_entry;
  logic               issue;
  logic               match;
  stamp_t             fresh;

  glc_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ENTRIES)
  ) u_tags (
    .clk   (clk),
    .we    (ram_we),
    .waddr (target_r),
    .wdata (ram_wdata),
    .raddr (addr_r[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  assign rd_entry  = entry_t'(ram_rdata);
  assign issue     = (addr_r < fill_r);
  assign match     = pend_r && (rd_entry.key == key_r) && (rd_entry.angle == angle_r);
  assign fresh     = (counter_r == STAMP_MAX) ? counter_r : counter_r + 1'b1;
  assign ram_we    = (state_r == ST_WRITE);
  assign ram_wdata = '{key: key_r, angle: angle_r, stamp: fresh};

  assign in_ready    = (state_r == ST_IDLE);
  assign out_valid   = (state_r == ST_RESP);
  assign out_hit     = hit_r;
  assign out_evicted = evict_r;
  assign out_slot    = SLOT_W'(target_r);

  always_comb begin
    state_nxt     = state_r;
    key_nxt       = key_r;
    angle_nxt     = angle_r;
    addr_nxt      = addr_r;
    fill_nxt      = fill_r;
    pend_nxt      = pend_r;
    pidx_nxt      = pidx_r;
    have_old_nxt  = have_old_r;
    old_stamp_nxt = old_stamp_r;
    old_slot_nxt  = old_slot_r;
    target_nxt    = target_r;
    hit_nxt       = hit_r;
    evict_nxt     = evict_r;
    counter_nxt   = counter_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          key_nxt      = {in_glyph_index, in_pixel_size, in_style_bits};
          angle_nxt    = angle_t'(in_rotation);
          addr_nxt     = '0;
          pend_nxt     = 1'b0;
          have_old_nxt = 1'b0;
          state_nxt    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (match) begin
          target_nxt = pidx_r;
          hit_nxt    = 1'b1;
          evict_nxt  = 1'b0;
          pend_nxt   = 1'b0;
          state_nxt  = ST_WRITE;
        end else begin
          if (pend_r && (!have_old_r || rd_entry.stamp < old_stamp_r)) begin
            have_old_nxt  = 1'b1;
            old_stamp_nxt = rd_entry.stamp;
            old_slot_nxt  = pidx_r;
          end
          if (issue) begin
            pend_nxt = 1'b1;
            pidx_nxt = addr_r[IDX_W-1:0];
            addr_nxt = addr_r + 1'b1;
          end else if (!pend_r) begin
            hit_nxt   = 1'b0;
            state_nxt = ST_WRITE;
            if (fill_r < CNT_W'(ENTRIES)) begin
              target_nxt = fill_r[IDX_W-1:0];
              fill_nxt   = fill_r + 1'b1;
              evict_nxt  = 1'b0;
            end else begin
              target_nxt = old_slot_r;
              evict_nxt  = 1'b1;
            end
          end else begin
            pend_nxt = 1'b0;
          end
        end
      end
      ST_WRITE: begin
        counter_nxt = fresh;
        state_nxt   = ST_RESP;
      end
      ST_RESP: begin
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      fill_r     <= '0;
      counter_r  <= '0;
      pend_r     <= 1'b0;
      have_old_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      fill_r     <= fill_nxt;
      counter_r  <= counter_nxt;
      pend_r     <= pend_nxt;
      have_old_r <= have_old_nxt;
    end
    key_r       <= key_nxt;
    angle_r     <= angle_nxt;
    addr_r      <= addr_nxt;
    pidx_r      <= pidx_nxt;
    old_stamp_r <= old_stamp_nxt;
    old_slot_r  <= old_slot_nxt;
    target_r    <= target_nxt;
    hit_r       <= hit_nxt;
    evict_r     <= evict_nxt;
  end

endmodule

`default_nettype wire
